[rtl/wsp_pkg.sv]
`timescale 1ns / 1ps
package wsp_pkg;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] sample;
      logic [15:0] channel;
      logic [2:0]  error;
      logic [31:0] frame_total;
      logic [15:0] channel_total;
      logic [31:0] rate;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_RIFF = 4'd0, PH_HDR = 4'd1, PH_FMT = 4'd2, PH_SKIP = 4'd3,
      PH_PAD = 4'd4, PH_DATA = 4'd5, PH_DONE = 4'd6
   } phase_type;

   localparam logic [2:0] ERR_OK = 3'd0;
   localparam logic [2:0] ERR_HEADER = 3'd1;
   localparam logic [2:0] ERR_SHORT_FMT = 3'd2;
   localparam logic [2:0] ERR_NO_FMT = 3'd3;
   localparam logic [2:0] ERR_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ERR_NO_FRAME = 3'd5;
   localparam logic [2:0] ERR_TRUNCATED = 3'd6;

   localparam logic [31:0] TAG_FMT = 32'h20746D66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [15:0] FMT_PCM = 16'h0001;
   localparam logic [15:0] FMT_FLOAT = 16'h0003;
   localparam logic [15:0] FMT_EXT = 16'hFFFE;

   localparam int QUEUE_DEPTH = 4;

   // work item from the parser to the sample back end
   typedef struct packed {
      logic        is_sample;
      logic        is_status;
      logic        is_float;
      logic [1:0]  nbytes;
      logic [31:0] raw;
      logic [15:0] channel;
      logic [2:0]  error;
      logic [31:0] frame_total;
      logic [15:0] channel_total;
      logic [31:0] rate;
   } job_type;

   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      unique case (idx)
         4'd0: magic_byte = 8'h52;
         4'd1: magic_byte = 8'h49;
         4'd2: magic_byte = 8'h46;
         4'd3: magic_byte = 8'h46;
         4'd8: magic_byte = 8'h57;
         4'd9: magic_byte = 8'h41;
         4'd10: magic_byte = 8'h56;
         4'd11: magic_byte = 8'h45;
         default: magic_byte = 8'h00;
      endcase
   endfunction

endpackage

[rtl/wsp_front.sv]
`timescale 1ns / 1ps
module wsp_front import wsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   input  logic    room,
   output logic    in_ready,
   output logic    job_valid,
   output job_type job_a,
   output logic    job_b_valid,
   output job_type job_b
);

   phase_type   phase_ff, phase_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] ftag_ff, ftag_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic        fseen_ff, fseen_in;
   logic [31:0] buf_ff, buf_in;
   logic [1:0]  bis_ff, bis_in;
   logic [15:0] chc_ff, chc_in;
   logic [31:0] frm_ff, frm_in;

   logic        go;
   logic [7:0]  b;
   logic [2:0]  err;
   logic        data_done;
   logic        smp;
   logic [1:0]  nb_m1;
   logic [2:0]  nb;
   logic [31:0] raw;
   logic [15:0] smp_ch;
   logic [4:0]  bsh;
   logic [15:0] chc_inc;
   logic [2:0]  derr;

   assign in_ready = room;
   assign go = in_valid && room;
   assign b = in_req.byte_req;
   assign nb = bits_ff[5:3];
   assign bsh = {off_ff[1:0], 3'b000};

   // format check at the data header
   always_comb begin
      if (!fseen_ff) derr = ERR_NO_FMT;
      else if (chans_ff == 16'd0 || rate_ff == 32'd0) derr = ERR_UNSUPPORTED;
      else if (ftag_ff != FMT_PCM && ftag_ff != FMT_FLOAT) derr = ERR_UNSUPPORTED;
      else if (bits_ff == 16'd0 || bits_ff[2:0] != 3'd0 || bits_ff > 16'd32)
         derr = ERR_UNSUPPORTED;
      else if (ftag_ff == FMT_FLOAT && bits_ff != 16'd32) derr = ERR_UNSUPPORTED;
      else derr = ERR_OK;
   end

   // parser next state
   always_comb begin
      phase_in = phase_ff; off_in = off_ff; tag_in = tag_ff; len_in = len_ff;
      ftag_in = ftag_ff; chans_in = chans_ff; rate_in = rate_ff; bits_in = bits_ff;
      fseen_in = fseen_ff; buf_in = buf_ff; bis_in = bis_ff; chc_in = chc_ff;
      frm_in = frm_ff;
      err = ERR_OK; data_done = 1'b0; smp = 1'b0; raw = 32'd0; smp_ch = chc_ff;
      nb_m1 = nb[1:0] - 2'd1; chc_inc = chc_ff + 16'd1;
      unique case (phase_ff)
         PH_RIFF: begin
            if ((off_ff < 32'd4 || off_ff >= 32'd8) && b != magic_byte(off_ff[3:0]))
               err = ERR_HEADER;
            if (off_ff >= 32'd11) begin
               phase_in = PH_HDR; off_in = 32'd0;
            end else off_in = off_ff + 32'd1;
         end
         PH_HDR: begin
            if (off_ff[2] == 1'b0)
               tag_in = ((off_ff == 32'd0) ? 32'd0 : tag_ff) | ({24'd0, b} << bsh);
            else
               len_in = ((off_ff == 32'd4) ? 32'd0 : len_ff) | ({24'd0, b} << bsh);
            if (off_ff < 32'd7) off_in = off_ff + 32'd1;
            else begin
               off_in = 32'd0;
               if (tag_ff == TAG_FMT) begin
                  if (len_in < 32'd16) err = ERR_SHORT_FMT;
                  else phase_in = PH_FMT;
               end else if (tag_ff == TAG_DATA) begin
                  err = derr;
                  if (err == ERR_OK && len_in == 32'd0) err = ERR_NO_FRAME;
                  if (err == ERR_OK) begin
                     phase_in = PH_DATA; bis_in = 2'd0; buf_in = 32'd0;
                     chc_in = 16'd0; frm_in = 32'd0;
                  end
               end else phase_in = (len_in == 32'd0) ? PH_HDR : PH_SKIP;
            end
         end
         PH_FMT, PH_SKIP: begin
            if (phase_ff == PH_FMT) begin
               unique case (off_ff)
                  32'd0: ftag_in = {8'd0, b};
                  32'd1: ftag_in = {b, ftag_ff[7:0]};
                  32'd2: chans_in = {8'd0, b};
                  32'd3: chans_in = {b, chans_ff[7:0]};
                  32'd4: rate_in = {24'd0, b};
                  32'd5, 32'd6, 32'd7: rate_in = rate_ff | ({24'd0, b} << bsh);
                  32'd14: bits_in = {8'd0, b};
                  32'd15: bits_in = {b, bits_ff[7:0]};
                  32'd24: tag_in = {24'd0, b};
                  32'd25: if (ftag_ff == FMT_EXT) ftag_in = {b, tag_ff[7:0]};
                  default: ;
               endcase
            end
            if (off_ff + 32'd1 >= len_ff) begin
               if (phase_ff == PH_FMT) fseen_in = 1'b1;
               phase_in = len_ff[0] ? PH_PAD : PH_HDR;
               off_in = 32'd0;
            end else off_in = off_ff + 32'd1;
         end
         PH_PAD: begin
            phase_in = PH_HDR; off_in = 32'd0;
         end
         PH_DATA: begin
            raw = ((bis_ff == 2'd0) ? 32'd0 : buf_ff) | ({24'd0, b} << {bis_ff, 3'b000});
            buf_in = raw;
            if ({1'b0, bis_ff} + 3'd1 >= nb) begin
               smp = 1'b1; bis_in = 2'd0;
               if (chc_inc >= chans_ff) begin
                  chc_in = 16'd0; frm_in = frm_ff + 32'd1;
               end else chc_in = chc_inc;
            end else bis_in = bis_ff + 2'd1;
            if (off_ff + 32'd1 >= len_ff) data_done = 1'b1;
            else off_in = off_ff + 32'd1;
         end
         default: ;
      endcase
   end

   // result jobs for this byte
   always_comb begin
      job_type st;
      logic    emit_st;
      st = '0;
      st.is_status = 1'b1;
      st.channel_total = chans_in;
      st.rate = rate_in;
      emit_st = 1'b0;
      if (phase_ff != PH_DONE) begin
         if (err == ERR_OK && (data_done || (in_req.end_of_input && phase_in == PH_DATA)))
         begin
            emit_st = 1'b1;
            if (frm_in == 32'd0) st.error = ERR_NO_FRAME;
            else st.frame_total = frm_in;
         end else if (err == ERR_OK && in_req.end_of_input) begin
            emit_st = 1'b1;
            st.error = (phase_in == PH_RIFF) ? ERR_HEADER : ERR_TRUNCATED;
         end else if (err != ERR_OK) begin
            emit_st = 1'b1;
            st.error = err;
         end
      end
      job_a = '0;
      job_a.is_sample = 1'b1;
      job_a.is_float = (ftag_ff == FMT_FLOAT);
      job_a.nbytes = nb_m1;
      job_a.raw = raw;
      job_a.channel = smp_ch;
      job_b = st;
      job_valid = 1'b0;
      job_b_valid = 1'b0;
      if (go && phase_ff != PH_DONE) begin
         if (smp) begin
            job_valid = 1'b1;
            job_b_valid = emit_st;
         end else if (emit_st) begin
            job_valid = 1'b1;
            job_a = st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF; off_ff <= '0; tag_ff <= '0; len_ff <= '0;
         ftag_ff <= '0; chans_ff <= '0; rate_ff <= '0; bits_ff <= '0;
         fseen_ff <= 1'b0; buf_ff <= '0; bis_ff <= '0; chc_ff <= '0; frm_ff <= '0;
      end else if (go && phase_ff != PH_DONE) begin
         phase_ff <= (err != ERR_OK || data_done || in_req.end_of_input) ?
                     PH_DONE : phase_in;
         off_ff <= off_in; tag_ff <= tag_in; len_ff <= len_in;
         ftag_ff <= ftag_in; chans_ff <= chans_in; rate_ff <= rate_in;
         bits_ff <= bits_in; fseen_ff <= fseen_in; buf_ff <= buf_in;
         bis_ff <= bis_in; chc_ff <= chc_in; frm_ff <= frm_in;
      end
   end

endmodule

[rtl/wsp_queue.sv]
`timescale 1ns / 1ps
module wsp_queue import wsp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_a,
   input  job_type data_a,
   input  logic    wr_b,
   input  job_type data_b,
   output logic    room,
   input  logic    rd,
   output logic    valid,
   output job_type data_out,
   output logic    out_last
);

   localparam int AW = $clog2(DEPTH);

   job_type        mem_ff [DEPTH];
   logic           lastm_ff [DEPTH];
   logic [AW-1:0]  wp_ff, rp_ff;
   logic [AW:0]    cnt_ff;
   logic [AW-1:0]  wp1;
   logic [AW:0]    nw;

   assign wp1 = wp_ff + 1'b1;
   assign nw = {{AW{1'b0}}, wr_a} + {{AW{1'b0}}, wr_b};
   // room for two entries keeps both results of one request together
   assign room = (cnt_ff + (AW + 1)'(2)) <= (AW + 1)'(DEPTH);
   assign valid = cnt_ff != '0;
   assign data_out = mem_ff[rp_ff];
   assign out_last = lastm_ff[rp_ff];

   // storage
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_ff[wp_ff] <= data_a;
         lastm_ff[wp_ff] <= !wr_b;
      end
      if (wr_b) begin
         mem_ff[wp1] <= data_b;
         lastm_ff[wp1] <= 1'b1;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_ff + nw[AW-1:0];
         if (rd && valid) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + nw - {{AW{1'b0}}, rd && valid};
      end
   end

endmodule

[rtl/wsp_back.sv]
`timescale 1ns / 1ps
module wsp_back import wsp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   input  logic    job_last,
   output logic    job_pop,
   output logic    out_valid,
   output rsp_type out_rsp,
   input  logic    out_pop
);

   logic    valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    load;

   assign load = job_valid && (!valid_ff || out_pop);
   assign job_pop = load;
   assign out_valid = valid_ff;
   assign out_rsp = rsp_ff;

   // sample conversion to q1.31
   always_comb begin
      logic        s;
      logic [7:0]  e;
      logic [23:0] m;
      logic [31:0] mag;
      logic [31:0] v;
      logic [7:0]  rs;
      s = job.raw[31]; e = job.raw[30:23]; m = {1'b1, job.raw[22:0]};
      mag = 32'd0; rs = 8'd0;
      if (job.is_float) begin
         if (e == 8'hFF) v = (job.raw[22:0] != 0) ? 32'd0 : (s ? 32'h80000000 : 32'h7FFFFFFF);
         else if (e == 8'd0) v = 32'd0;
         else if (e >= 8'd127) v = s ? 32'h80000000 : 32'h7FFFFFFF;
         else begin
            if (e >= 8'd119) mag = {8'd0, m} << (e - 8'd119);
            else begin
               rs = 8'd119 - e;
               mag = (rs < 8'd32) ? ({8'd0, m} >> rs) : 32'd0;
            end
            v = s ? (32'd0 - mag) : mag;
         end
      end else begin
         unique case (job.nbytes)
            2'd0: v = {job.raw[7:0] ^ 8'h80, 24'd0};
            2'd1: v = {job.raw[15:0], 16'd0};
            2'd2: v = {job.raw[23:0], 8'd0};
            default: v = job.raw;
         endcase
      end
      rsp_in.kind = job.is_status;
      rsp_in.sample = job.is_sample ? v : 32'd0;
      rsp_in.channel = job.channel;
      rsp_in.error = job.error;
      rsp_in.frame_total = job.frame_total;
      rsp_in.channel_total = job.channel_total;
      rsp_in.rate = job.rate;
      rsp_in.last = job_last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (out_pop) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

endmodule

[rtl/wav_stream_parser_decoder_core.sv]
`timescale 1ns / 1ps
// channel   ports                       meaning
// request   req_push req_data req_full  one file byte per request
// result    rsp_pop rsp_data rsp_empty  samples and one final status
// one byte per cycle while the queue has room; a byte's results pass a
// DEPTH-entry queue (four by default) and then an output register.
// the front part stalls (full) only when the queue cannot hold two more.
// synchronous reset returns to header search; after the status, bytes are
// taken and dropped until reset.
module wav_stream_parser_decoder_core import wsp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   input  logic    rsp_pop,
   output rsp_type rsp_data,
   output logic    rsp_empty
);

   logic    room, ready, wr_a, wr_b, q_valid, q_last, q_pop, out_valid;
   job_type ja, jb, q_job;

   assign req_full = !ready;
   assign rsp_empty = !out_valid;

   wsp_front u_front (
      .clock, .reset, .in_valid(req_push), .in_req(req_data), .room,
      .in_ready(ready), .job_valid(wr_a), .job_a(ja), .job_b_valid(wr_b), .job_b(jb)
   );

   wsp_queue #(.DEPTH(DEPTH)) u_queue (
      .clock, .reset, .wr_a, .data_a(ja), .wr_b, .data_b(jb), .room,
      .rd(q_pop), .valid(q_valid), .data_out(q_job), .out_last(q_last)
   );

   wsp_back u_back (
      .clock, .reset, .job_valid(q_valid), .job(q_job), .job_last(q_last),
      .job_pop(q_pop), .out_valid, .out_rsp(rsp_data), .out_pop(rsp_pop)
   );

endmodule
